/* hdl/dwm_pkg.sv */
// shared definitions for the dct coefficient-pair watermark block
// command codes, field widths and default parameter values; no dependencies
package dwm_pkg;

	localparam int CMD_W = 2;
	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_EMBED   = 2'd0;
	localparam cmd_t CMD_EXTRACT = 2'd1;
	localparam cmd_t CMD_START   = 2'd2;
	localparam cmd_t CMD_UNUSED  = 2'd3;

	localparam int MARGIN_W = 10;
	typedef logic [MARGIN_W-1:0] margin_t;
	localparam margin_t MARGIN_RESET = 10'd80;

	localparam int BYTE_CNT_W = 7;
	typedef logic [BYTE_CNT_W-1:0] byte_cnt_t;
	typedef logic [2:0] bit_pos_t;
	typedef logic [7:0] byte_t;

	localparam int MESSAGE_BYTES_DEF = 127;
	localparam int COEF_WIDTH_DEF    = 16;

endpackage

/* hdl/dct_watermark_bit_embed_extract.sv */
// top level of the dct coefficient-pair watermark embed / extract block
// depends on dwm_pkg and dwm_pair
//
// One request carries the five low coefficients of one 8x8 dct block and a
// command. Embed forces the order of the pairs (c01,c10) and (c02,c20) and
// the sign of c11 to carry message_bit, pushing close pairs apart by margin.
// Extract votes over the three tests and packs bits msb first; byte_valid
// marks the block that completes a byte. Start clears the bit and byte
// counters. After MESSAGE_BYTES bytes, blocks pass unchanged and
// message_done stays high until the next start. Throughput is one request
// per clock while res_stall is low: a request waits in the input register
// while the embed and vote logic runs, and the response register captures
// the result, which drives res_valid. The counters are updated as a
// request moves into the response register, so requests stream back to
// back and the input side keeps taking requests while a response waits,
// stalling only when both registers are full. margin is written through
// margin_we / margin_wdata and resets to 5.0 in Q6.4; the user must write
// it only while the block is idle, which the block itself does not enforce.
module dct_watermark_bit_embed_extract #(
	parameter int MESSAGE_BYTES = dwm_pkg::MESSAGE_BYTES_DEF,
	parameter int COEF_WIDTH    = dwm_pkg::COEF_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         margin_we,
	input  dwm_pkg::margin_t             margin_wdata,
	// request channel
	input  logic                         req_valid,
	output logic                         req_stall,
	input  dwm_pkg::cmd_t                command,
	input  logic                         message_bit,
	input  logic signed [COEF_WIDTH-1:0] coef_01_in,
	input  logic signed [COEF_WIDTH-1:0] coef_10_in,
	input  logic signed [COEF_WIDTH-1:0] coef_02_in,
	input  logic signed [COEF_WIDTH-1:0] coef_20_in,
	input  logic signed [COEF_WIDTH-1:0] coef_11_in,
	// response channel
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic signed [COEF_WIDTH-1:0] coef_01_out,
	output logic signed [COEF_WIDTH-1:0] coef_10_out,
	output logic signed [COEF_WIDTH-1:0] coef_02_out,
	output logic signed [COEF_WIDTH-1:0] coef_20_out,
	output logic signed [COEF_WIDTH-1:0] coef_11_out,
	output logic                         byte_valid,
	output dwm_pkg::byte_t               extracted_byte,
	output logic                         message_done
);
	import dwm_pkg::*;

	localparam int W = COEF_WIDTH;
	localparam byte_cnt_t MSG_BYTES = BYTE_CNT_W'(MESSAGE_BYTES);
	localparam logic signed [W-1:0] COEF_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] COEF_MIN = {1'b1, {(W-1){1'b0}}};

	// configuration register
	margin_t margin_q;

	// message state
	bit_pos_t  bit_pos_q;
	byte_t     acc_q;
	byte_cnt_t bytes_done_q;

	// input register
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic                bit_s1;
	logic signed [W-1:0] c01_s1, c10_s1, c02_s1, c20_s1, c11_s1;

	// response register
	logic                valid_s2;
	logic signed [W-1:0] c01_s2, c10_s2, c02_s2, c20_s2, c11_s2;
	logic                byte_valid_s2;
	byte_t               byte_s2;
	logic                done_s2;

	// flow control
	logic adv_s2;
	logic load_s1;
	logic move_s1;

	assign adv_s2    = !valid_s2 || !res_stall;
	assign move_s1   = valid_s1 && adv_s2;
	assign req_stall = valid_s1 && !adv_s2;
	assign load_s1   = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
		end else if (margin_we) begin
			margin_q <= margin_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s2 || !valid_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1 <= command;
			bit_s1 <= message_bit;
			c01_s1 <= coef_01_in;
			c10_s1 <= coef_10_in;
			c02_s1 <= coef_02_in;
			c20_s1 <= coef_20_in;
			c11_s1 <= coef_11_in;
		end
	end

	// embed path
	logic signed [W-1:0] emb_c01, emb_c10, emb_c02, emb_c20;
	logic signed [W-1:0] c11_mag;
	logic signed [W-1:0] emb_c11;

	dwm_pair #(.COEF_WIDTH(W)) u_pair_hi (
		.a      (c02_s1),
		.b      (c20_s1),
		.bit_val(bit_s1),
		.margin (margin_q),
		.a_out  (emb_c02),
		.b_out  (emb_c20)
	);

	dwm_pair #(.COEF_WIDTH(W)) u_pair_lo (
		.a      (c01_s1),
		.b      (c10_s1),
		.bit_val(bit_s1),
		.margin (margin_q),
		.a_out  (emb_c01),
		.b_out  (emb_c10)
	);

	// magnitude wraps only for the most negative value, handled below
	assign c11_mag = c11_s1[W-1] ? -c11_s1 : c11_s1;

	always_comb begin
		if (bit_s1) begin
			// |c11|+1 saturated; the most negative input maps to the maximum
			if (c11_s1 == COEF_MIN || c11_mag == COEF_MAX) begin
				emb_c11 = COEF_MAX;
			end else begin
				emb_c11 = c11_mag + W'(1);
			end
		end else begin
			// -|c11|; negative values already are
			emb_c11 = c11_s1[W-1] ? c11_s1 : -c11_s1;
		end
	end

	// extract path: majority of three tests
	logic [2:0] votes;
	logic       vote_bit;
	byte_t      acc_new;

	assign votes[0] = c01_s1 > c10_s1;
	assign votes[1] = c02_s1 > c20_s1;
	assign votes[2] = c11_s1 > W'(0);
	assign vote_bit = (votes[0] && votes[1]) || (votes[0] && votes[2]) || (votes[1] && votes[2]);
	assign acc_new  = acc_q | (vote_bit ? (8'h80 >> bit_pos_q) : 8'h00);

	// next state and response
	logic                complete;
	logic                active;
	bit_pos_t            bit_pos_d;
	byte_t               acc_d;
	byte_cnt_t           bytes_done_d;
	logic signed [W-1:0] r_c01, r_c10, r_c02, r_c20, r_c11;
	logic                r_byte_valid;
	byte_t               r_byte;

	assign complete = bytes_done_q >= MSG_BYTES;

	always_comb begin
		bit_pos_d    = bit_pos_q;
		acc_d        = acc_q;
		bytes_done_d = bytes_done_q;
		r_c01        = c01_s1;
		r_c10        = c10_s1;
		r_c02        = c02_s1;
		r_c20        = c20_s1;
		r_c11        = c11_s1;
		r_byte_valid = 1'b0;
		r_byte       = 8'h00;
		active       = 1'b0;
		unique case (cmd_s1)
			CMD_START: begin
				bit_pos_d    = '0;
				acc_d        = '0;
				bytes_done_d = '0;
			end
			CMD_EMBED: begin
				if (!complete) begin
					active = 1'b1;
					r_c01  = emb_c01;
					r_c10  = emb_c10;
					r_c02  = emb_c02;
					r_c20  = emb_c20;
					r_c11  = emb_c11;
				end
			end
			CMD_EXTRACT: begin
				if (!complete) begin
					active = 1'b1;
					acc_d  = acc_new;
					if (bit_pos_q == 3'd7) begin
						r_byte_valid = 1'b1;
						r_byte       = acc_new;
						acc_d        = '0;
					end
				end
			end
			default: begin
			end
		endcase
		if (active) begin
			bit_pos_d = bit_pos_q + 3'd1;
			if (bit_pos_q == 3'd7) begin
				bytes_done_d = bytes_done_q + BYTE_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q    <= '0;
			acc_q        <= '0;
			bytes_done_q <= '0;
		end else if (move_s1) begin
			bit_pos_q    <= bit_pos_d;
			acc_q        <= acc_d;
			bytes_done_q <= bytes_done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			c01_s2        <= r_c01;
			c10_s2        <= r_c10;
			c02_s2        <= r_c02;
			c20_s2        <= r_c20;
			c11_s2        <= r_c11;
			byte_valid_s2 <= r_byte_valid;
			byte_s2       <= r_byte;
			done_s2       <= bytes_done_d >= MSG_BYTES;
		end
	end

	assign res_valid      = valid_s2;
	assign coef_01_out    = c01_s2;
	assign coef_10_out    = c10_s2;
	assign coef_02_out    = c02_s2;
	assign coef_20_out    = c20_s2;
	assign coef_11_out    = c11_s2;
	assign byte_valid     = byte_valid_s2;
	assign extracted_byte = byte_s2;
	assign message_done   = done_s2;

`ifndef NO_ASSERTIONS
	// byte counter never runs past the message length
	a_bytes_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_done_q <= MSG_BYTES)
		else $error("bytes_done past message length");

	// a completed byte leaves the bit position and accumulator cleared
	a_byte_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && byte_valid_s2 |-> (bit_pos_q == 3'd0 && acc_q == 8'h00))
		else $error("byte completed without counter wrap");

	// message_done shown with a response matches the held counter
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && done_s2 |-> bytes_done_q == MSG_BYTES)
		else $error("message_done disagrees with byte counter");

	// input side stalls only when its register holds a request
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && valid_s2 && res_stall)
		else $error("request stalled without a full pipeline");
`endif

endmodule

/* hdl/dwm_pair.sv */
// embed step for one coefficient pair: margin adjust with saturation, then order by bit
// depends on dwm_pkg
module dwm_pair #(
	parameter int COEF_WIDTH = dwm_pkg::COEF_WIDTH_DEF
) (
	input  logic signed [COEF_WIDTH-1:0] a,
	input  logic signed [COEF_WIDTH-1:0] b,
	input  logic                         bit_val,
	input  dwm_pkg::margin_t             margin,
	output logic signed [COEF_WIDTH-1:0] a_out,
	output logic signed [COEF_WIDTH-1:0] b_out
);
	import dwm_pkg::*;

	localparam int W = COEF_WIDTH;

	logic signed [W:0]   diff;
	logic        [W:0]   abs_diff;
	logic                close;
	logic                a_lt_b;
	logic signed [W-1:0] sub_src;
	logic signed [W:0]   sub_ext;
	logic signed [W-1:0] sub_sat;
	logic signed [W-1:0] adj_a;
	logic signed [W-1:0] adj_b;
	logic                swap;
	margin_t             m;

	assign m        = margin;
	assign diff     = {a[W-1], a} - {b[W-1], b};
	assign abs_diff = diff[W] ? $unsigned(-diff) : $unsigned(diff);
	assign close    = abs_diff < (W+1)'(m);
	assign a_lt_b   = a < b;

	// the smaller member loses the margin, the second one on a tie
	assign sub_src = a_lt_b ? a : b;
	assign sub_ext = {sub_src[W-1], sub_src} - $signed({1'b0, (W)'(m)});
	assign sub_sat = (sub_ext[W] != sub_ext[W-1]) ? {1'b1, {(W-1){1'b0}}} : sub_ext[W-1:0];

	assign adj_a = (close && a_lt_b)  ? sub_sat : a;
	assign adj_b = (close && !a_lt_b) ? sub_sat : b;

	assign swap  = bit_val ? (adj_a < adj_b) : (adj_a > adj_b);
	assign a_out = swap ? adj_b : adj_a;
	assign b_out = swap ? adj_a : adj_b;

endmodule
